/* design/lpss_pkg.sv */
// Shared types and constants for the LMS predictive sample suppressor.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpss_pkg;

   // Default number of predictor taps
   localparam int LPSS_TAPS = 8;

   // Field and register widths
   localparam int SAMPLE_W   = 16;
   localparam int WEIGHT_W   = 32;
   localparam int STEP_W     = 32;
   localparam int COUNT_W    = 17;
   localparam int THR_W      = 8;
   localparam int HITS_W     = 16;
   localparam int MODE_W     = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Saturation point of the hit counter
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_THRESHOLD    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HITS_TO_STANDALONE = 1'b1;

   // Operating phase
   localparam logic [MODE_W-1:0] PH_INIT       = 2'd0;
   localparam logic [MODE_W-1:0] PH_NORMAL     = 2'd1;
   localparam logic [MODE_W-1:0] PH_STANDALONE = 2'd2;

   // Control handed to every cell of the ring
   typedef struct packed {
      logic rotate;   // move sample and weight one place toward the head
      logic shift;    // move samples only, new sample enters at the tail
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* design/lpss_cell.sv */
// One tap of the predictor ring: holds a history sample and its weight.
// Depends on lpss_pkg.
`default_nettype none

module lpss_cell (
   input  wire                                  clock,
   input  wire                                  reset,
   input  lpss_pkg::cell_ctrl_type              ctrl,
   input  wire  signed [lpss_pkg::SAMPLE_W-1:0] x_in,
   input  wire  signed [lpss_pkg::WEIGHT_W-1:0] w_in,
   output logic signed [lpss_pkg::SAMPLE_W-1:0] x_out,
   output logic signed [lpss_pkg::WEIGHT_W-1:0] w_out
);
   import lpss_pkg::*;

   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [WEIGHT_W-1:0] w_ff;

   // Take the neighbor's pair on rotate, only its sample on shift
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         w_ff <= '0;
      end else if (ctrl.rotate) begin
         x_ff <= x_in;
         w_ff <= w_in;
      end else if (ctrl.shift) begin
         x_ff <= x_in;
      end
   end

   assign x_out = x_ff;
   assign w_out = w_ff;

endmodule

`default_nettype wire

/* design/lpss_div.sv */
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// Depends on lpss_pkg.
`default_nettype none

module lpss_div #(
   parameter int NUM_W = 52,
   parameter int DEN_W = 41
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire  [NUM_W-1:0]                numer,
   input  wire  [DEN_W-1:0]                denom,
   output logic                            done,
   output logic [lpss_pkg::STEP_W-1:0]     quot
);
   import lpss_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic             ovf_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [STEP_W-1:0] q_ff;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_in;
   logic             qbit;

   // Trial subtract of the divisor from the shifted remainder
   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      qbit   = (rem_sh >= {1'b0, den_ff});
      rem_in = qbit ? (rem_sh - {1'b0, den_ff}) : rem_sh;
   end

   // Iterate over every numerator bit; flag any quotient bit above 32 bits
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numer;
         den_ff <= denom;
         rem_ff <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_in[DEN_W-1:0];
         q_ff   <= {q_ff[STEP_W-2:0], qbit};
         ovf_ff <= ovf_ff | q_ff[STEP_W-1];
      end
   end

   assign done = done_ff;
   assign quot = ovf_ff ? '1 : q_ff;

endmodule

`default_nettype wire

/* design/lms_predictive_sample_suppressor_unit.sv */
// Top level of the LMS predictive sample suppressor: sequencer, shared MAC,
// weight update and output register. Depends on lpss_pkg, lpss_cell, lpss_div.
//
//   Port group   Dir  Handshake          Payload
//   req_*        in   tvalid/tready      tdata[15:0] sample
//   rsp_*        out  tvalid/tready      tdata[0] suppressed, [16:1] prediction,
//                                        [18:17] mode
//   csr_*        in   csr_we             csr_index, csr_wdata
//
// The single MAC walks the tap ring once to predict and, unless a standalone
// hit skips it, once to adapt. Early init requests only prime the history; the
// last one walks the ring for window energy and runs the divider for the step
// size. One request is in work at a time; the output register lets the next
// request enter while a response waits. Reset is synchronous and clears
// history, weights, step size, phase and counter.
`default_nettype none

module lms_predictive_sample_suppressor_unit #(
   parameter int TAPS = lpss_pkg::LPSS_TAPS
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [lpss_pkg::REQ_DATA_W-1:0]     req_tdata,   // [15:0] sample
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [lpss_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [0] suppressed,
                                                            // [16:1] prediction,
                                                            // [18:17] mode
   input  wire                                 csr_we,
   input  wire  [lpss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [lpss_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lpss_pkg::*;

   localparam int TW    = $clog2(TAPS);
   localparam int ACC_W = 48 + TW;
   localparam int S_W   = 31 + TW;
   localparam int DEN_W = S_W + 7;
   localparam int NUM_W = 49 + TW;
   localparam int ERR_W = SAMPLE_W + 1;
   localparam int T_W   = 34;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_ENERGY  = 8'b0000_0010,
      ST_DIVIDE  = 8'b0000_0100,
      ST_PREDICT = 8'b0000_1000,
      ST_ERROR   = 8'b0001_0000,
      ST_STEP    = 8'b0010_0000,
      ST_ADAPT   = 8'b0100_0000,
      ST_COMMIT  = 8'b1000_0000
   } state_type;

   state_type                   state_ff;
   logic [THR_W-1:0]            thr_ff;
   logic [HITS_W-1:0]           hits_ff;
   logic [MODE_W-1:0]           phase_ff;
   logic [COUNT_W-1:0]          count_ff;
   logic [STEP_W-1:0]           step_ff;
   logic signed [SAMPLE_W-1:0]  sample_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic [TW-1:0]               ctr_ff;
   logic signed [SAMPLE_W-1:0]  pred_ff;
   logic signed [ERR_W-1:0]     err_ff;
   logic                        hit_ff;
   logic signed [T_W-1:0]       t_ff;
   logic                        div_start_ff;
   logic                        rsp_valid_ff;
   logic [RSP_DATA_W-1:0]       rsp_data_ff;

   // Ring of cells
   logic signed [SAMPLE_W-1:0]  x_q [TAPS];
   logic signed [WEIGHT_W-1:0]  w_q [TAPS];
   cell_ctrl_type               cell_ctrl;
   logic signed [SAMPLE_W-1:0]  tail_x;
   logic signed [WEIGHT_W-1:0]  tail_w;
   logic signed [SAMPLE_W-1:0]  head_x;
   logic signed [WEIGHT_W-1:0]  head_w;

   logic                        out_free;
   logic                        last_tap;
   logic                        supp_c;
   logic signed [WEIGHT_W-1:0]  mac_a;
   logic signed [47:0]          mac_prod;
   logic signed [ACC_W-25:0]    acc_hi;
   logic signed [SAMPLE_W-1:0]  pred_c;
   logic signed [ERR_W-1:0]     err_c;
   logic [ERR_W-1:0]            mag_c;
   logic                        hit_c;
   logic signed [49:0]          t_prod;
   logic signed [49:0]          w_prod;
   logic signed [50:0]          wsum;
   logic signed [WEIGHT_W-1:0]  w_upd;
   logic [DEN_W-1:0]            div_den;
   logic                        div_done;
   logic [STEP_W-1:0]           div_quot;
   logic [COUNT_W-1:0]          count_in;
   logic [COUNT_W-1:0]          inc_cnt;
   logic [MODE_W-1:0]           phase_in;

   assign head_x   = x_q[0];
   assign head_w   = w_q[0];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign last_tap = (ctr_ff == TW'(TAPS - 1));
   assign supp_c   = (phase_ff != PH_INIT) && (phase_ff != PH_NORMAL) && hit_ff;

   // Drive the ring: rotate during MAC passes, shift on commit
   always_comb begin
      cell_ctrl.rotate = (state_ff == ST_ENERGY) || (state_ff == ST_PREDICT) ||
                         (state_ff == ST_ADAPT);
      cell_ctrl.shift  = (state_ff == ST_COMMIT) && out_free;
      tail_x = cell_ctrl.rotate ? head_x : (supp_c ? pred_ff : sample_ff);
      tail_w = (state_ff == ST_ADAPT) ? w_upd : head_w;
   end

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      logic signed [SAMPLE_W-1:0] x_nb;
      logic signed [WEIGHT_W-1:0] w_nb;
      if (i == TAPS - 1) begin : g_tail
         assign x_nb = tail_x;
         assign w_nb = tail_w;
      end else begin : g_mid
         assign x_nb = x_q[i+1];
         assign w_nb = w_q[i+1];
      end
      lpss_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (cell_ctrl),
         .x_in  (x_nb),
         .w_in  (w_nb),
         .x_out (x_q[i]),
         .w_out (w_q[i])
      );
   end

   // Shared MAC: sample squared for energy, weight times sample for prediction
   always_comb begin
      mac_a    = (state_ff == ST_ENERGY) ? WEIGHT_W'(head_x) : head_w;
      mac_prod = mac_a * head_x;
   end

   // Prediction, error and hit test from the accumulated sum
   always_comb begin
      acc_hi = acc_ff[ACC_W-1:24];
      if (acc_hi[ACC_W-25:15] == '0 || acc_hi[ACC_W-25:15] == '1) begin
         pred_c = acc_hi[SAMPLE_W-1:0];
      end else begin
         pred_c = acc_hi[ACC_W-25] ? 16'sh8000 : 16'sh7FFF;
      end
      err_c = ERR_W'(sample_ff) - ERR_W'(pred_c);
      mag_c = err_c[ERR_W-1] ? ERR_W'(-err_c) : ERR_W'(err_c);
      hit_c = (mag_c <= ERR_W'(thr_ff));
   end

   // Step term and saturated weight update for the head cell
   always_comb begin
      t_prod = $signed({1'b0, step_ff}) * err_ff;
      w_prod = t_ff * head_x;
      wsum   = 51'(head_w) + 51'($signed(w_prod[49:8]));
      if (wsum[50:31] == '0 || wsum[50:31] == '1) begin
         w_upd = wsum[WEIGHT_W-1:0];
      end else begin
         w_upd = wsum[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
   end

   // Step size from window energy
   assign div_den = DEN_W'(acc_ff[S_W-1:0]) * DEN_W'(100);

   lpss_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .numer (NUM_W'(TAPS) << 48),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Phase and counter after this request
   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      inc_cnt  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      if (phase_ff == PH_INIT) begin
         if (count_ff >= COUNT_W'(TAPS - 1)) begin
            count_in = '0;
            phase_in = PH_NORMAL;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (phase_ff == PH_NORMAL) begin
         if (hit_ff) begin
            count_in = inc_cnt;
            if (inc_cnt > COUNT_W'(hits_ff)) begin
               phase_in = PH_STANDALONE;
            end
         end
      end else if (!hit_ff) begin
         count_in = '0;
         phase_in = PH_NORMAL;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THR_W'(16);
         hits_ff <= HITS_W'(32);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MATCH_THRESHOLD:    thr_ff  <= csr_wdata[THR_W-1:0];
            CSR_HITS_TO_STANDALONE: hits_ff <= csr_wdata[HITS_W-1:0];
            default: ;
         endcase
      end
   end

   // Pulse the divider start after the last energy tap
   always_ff @(posedge clock) begin
      if (reset) begin
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == ST_ENERGY) && last_tap;
      end
   end

   // Hold the response until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_COMMIT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_INIT;
         count_ff     <= '0;
         step_ff      <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  if (phase_ff != PH_INIT) begin
                     state_ff <= ST_PREDICT;
                  end else if (count_ff >= COUNT_W'(TAPS - 1)) begin
                     state_ff <= ST_ENERGY;
                  end else begin
                     state_ff <= ST_COMMIT;
                  end
               end
            end
            ST_ENERGY: begin
               if (last_tap) begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  step_ff  <= div_quot;
                  state_ff <= ST_COMMIT;
               end
            end
            ST_PREDICT: begin
               if (last_tap) begin
                  state_ff <= ST_ERROR;
               end
            end
            ST_ERROR: begin
               if (phase_ff != PH_NORMAL && hit_c) begin
                  state_ff <= ST_COMMIT;
               end else begin
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: state_ff <= ST_ADAPT;
            ST_ADAPT: begin
               if (last_tap) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (out_free) begin
                  phase_ff     <= phase_in;
                  count_ff     <= count_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff) inside
         ST_IDLE: begin
            sample_ff <= signed'(req_tdata[SAMPLE_W-1:0]);
            acc_ff    <= '0;
            ctr_ff    <= '0;
            hit_ff    <= 1'b0;
            pred_ff   <= '0;
         end
         ST_ENERGY, ST_PREDICT: begin
            acc_ff <= acc_ff + ACC_W'(mac_prod);
            ctr_ff <= ctr_ff + 1'b1;
         end
         ST_ERROR: begin
            pred_ff <= pred_c;
            err_ff  <= err_c;
            hit_ff  <= hit_c;
         end
         ST_STEP: begin
            t_ff   <= t_prod[49:16];
            ctr_ff <= '0;
         end
         ST_ADAPT: ctr_ff <= ctr_ff + 1'b1;
         ST_COMMIT: begin
            if (out_free) begin
               rsp_data_ff <= {5'b0, phase_in,
                               (phase_ff == PH_INIT) ? 16'h0000 : pred_ff, supp_c};
            end
         end
         default: ;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
